/* rtl/mtt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and codes for the transaction tracker.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int PEND_W = 7;

  typedef enum logic [1:0] {
    FUNC_SEND   = 2'd0,
    FUNC_RESP   = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_CANCEL = 2'd3
  } func_t;

  localparam logic [2:0] EV_SENT       = 3'd0;
  localparam logic [2:0] EV_REJECTED   = 3'd1;
  localparam logic [2:0] EV_COMPLETED  = 3'd2;
  localparam logic [2:0] EV_DROPPED    = 3'd3;
  localparam logic [2:0] EV_RETRANSMIT = 3'd4;
  localparam logic [2:0] EV_FAILED     = 3'd5;

  localparam logic [1:0] CFG_FRAMING = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_RETRY   = 2'd2;

  localparam logic        FRAMING_RESET = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [3:0]  RETRY_RESET   = 4'd2;

  typedef struct packed {
    logic [15:0] txn;
    logic [7:0]  unit;
    logic [31:0] tag;
    logic [4:0]  attempts;
    logic [15:0] remaining;
  } entry_t;

  typedef enum logic [2:0] {
    TOP_NOP    = 3'd0,
    TOP_APPEND = 3'd1,
    TOP_WRITE  = 3'd2,
    TOP_REMOVE = 3'd3,
    TOP_CLEAR  = 3'd4
  } tbl_op_t;

  typedef struct packed {
    tbl_op_t op;
    entry_t  wdata;
  } tbl_cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [15:0]       txn;
    logic [7:0]        unit;
    logic [31:0]       tag;
    logic [4:0]        att;
    logic [PEND_W-1:0] pend;
  } result_t;

  typedef struct packed {
    logic push;
    logic flush;
  } out_ctl_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } out_sts_t;

endpackage
`default_nettype wire

/* rtl/mtt_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_table
// Age-ordered entry table with one read port, append, update and removal.
// ----------------------------------------------------------------------------
module mtt_table import mtt_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tbl_cmd_t      cmd,
  input  wire logic [IW-1:0] idx,
  output entry_t             rdata,
  output logic [CW-1:0]      total
);

  entry_t          ent_r [DEPTH];
  logic [CW-1:0]   total_r;

  assign rdata = ent_r[idx];
  assign total = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      unique case (cmd.op)
        TOP_APPEND: total_r <= total_r + CW'(1);
        TOP_REMOVE: total_r <= total_r - CW'(1);
        TOP_CLEAR:  total_r <= '0;
        default:    total_r <= total_r;
      endcase
    end
  end

  // Removal moves every younger entry one slot toward the head.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.op == TOP_APPEND && total_r == CW'(i)) begin
        ent_r[i] <= cmd.wdata;
      end else if (cmd.op == TOP_WRITE && idx == IW'(i)) begin
        ent_r[i] <= cmd.wdata;
      end else if (cmd.op == TOP_REMOVE && IW'(i) >= idx && i < DEPTH - 1) begin
        ent_r[i] <= ent_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/mtt_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_out
// One-result hold stage plus output register; marks the last result of a run.
// ----------------------------------------------------------------------------
module mtt_out import mtt_pkg::*; #(
  parameter int CW = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire out_ctl_t ctl,
  input  wire result_t  res,
  output out_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [2:0]    out_event_kind,
  output logic [15:0]   out_txn_id,
  output logic [7:0]    out_unit,
  output logic [31:0]   out_tag,
  output logic [4:0]    out_attempt_count,
  output logic [CW-1:0] out_pending_count,
  output logic          out_last_of_run
);

  result_t hold_r, obuf_r;
  logic    hold_v_r, out_v_r, last_r;
  result_t hold_nxt, obuf_nxt;
  logic    hold_v_nxt, out_v_nxt, last_nxt;
  logic    can_go;

  assign can_go       = !out_v_r || out_ready;
  assign sts.push_ok  = !hold_v_r || can_go;
  assign sts.flush_ok = !hold_v_r || can_go;

  always_comb begin
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    obuf_nxt   = obuf_r;
    out_v_nxt  = out_v_r && !out_ready;
    last_nxt   = last_r;
    if (ctl.push && sts.push_ok) begin
      if (hold_v_r) begin
        out_v_nxt = 1'b1;
        obuf_nxt  = hold_r;
        last_nxt  = 1'b0;
      end
      hold_nxt   = res;
      hold_v_nxt = 1'b1;
    end else if (ctl.flush && hold_v_r && can_go) begin
      out_v_nxt  = 1'b1;
      obuf_nxt   = hold_r;
      last_nxt   = 1'b1;
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      hold_r   <= hold_nxt;
      obuf_r   <= obuf_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_event_kind    = obuf_r.kind;
  assign out_txn_id        = obuf_r.txn;
  assign out_unit          = obuf_r.unit;
  assign out_tag           = obuf_r.tag;
  assign out_attempt_count = obuf_r.att;
  assign out_pending_count = obuf_r.pend[CW-1:0];
  assign out_last_of_run   = last_r;

endmodule
`default_nettype wire

/* rtl/modbus_transaction_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_transaction_tracker
// Outstanding-request table for a Modbus master with timeout and retry.
// ----------------------------------------------------------------------------
// Timing: a send, or a response in RTU mode, puts its result in the hold stage
// and then in the output register; a TCP response compares the pending entries
// one compare a cycle, and a tick runs a scan pass and then a failure pass to its
// last result. One item at a time: in_ready returns with the edge that registers
// the last result. Output stalls can hold any step that passes on a result.
// Synchronous reset empties the table, restores register defaults and zeroes ids.
module modbus_transaction_tracker import mtt_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_unit_address,
  input  wire logic [31:0] in_request_tag,
  input  wire logic [15:0] in_response_txn_id,
  input  wire logic        in_response_ok,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [15:0]      out_txn_id,
  output logic [7:0]       out_unit,
  output logic [31:0]      out_tag,
  output logic [4:0]       out_attempt_count,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] out_pending_count,
  output logic             out_last_of_run
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEND, S_RESP, S_SCAN, S_FAIL, S_FLUSH
  } state_t;

  // Configuration registers.
  logic        framing_r;
  logic [15:0] timeout_r;
  logic [3:0]  retry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framing_r <= FRAMING_RESET;
      timeout_r <= TIMEOUT_RESET;
      retry_r   <= RETRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAMING: framing_r <= cfg_wdata[0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_RETRY:   retry_r   <= cfg_wdata[3:0];
        default:     ;
      endcase
    end
  end

  state_t               state_r;
  logic [IW-1:0]        idx_r;
  logic [TABLE_DEPTH-1:0] fail_r;
  logic [15:0]          next_txn_r;
  logic [7:0]           unit_r;
  logic [31:0]          tag_r;
  logic [15:0]          rtxn_r;
  logic                 rok_r;

  tbl_cmd_t      cmd;
  entry_t        rd;
  logic [CW-1:0] total;
  out_ctl_t      octl;
  out_sts_t      osts;
  result_t       res;

  mtt_table #(.DEPTH(TABLE_DEPTH), .IW(IW), .CW(CW)) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .idx   (idx_r),
    .rdata (rd),
    .total (total)
  );

  mtt_out #(.CW(CW)) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (octl),
    .res               (res),
    .sts               (osts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_txn_id        (out_txn_id),
    .out_unit          (out_unit),
    .out_tag           (out_tag),
    .out_attempt_count (out_attempt_count),
    .out_pending_count (out_pending_count),
    .out_last_of_run   (out_last_of_run)
  );

  assign in_ready = (state_r == S_IDLE);

  logic          accept;
  logic [15:0]   dec_rem;
  logic          expired;
  logic          can_retry;
  logic [IW-1:0] last_idx;
  logic [PEND_W-1:0] pend_now, pend_less;

  assign accept    = in_valid && in_ready;
  // The shared entry unit: one decrement and compare on the entry at idx_r.
  assign dec_rem   = (rd.remaining != 16'd0) ? rd.remaining - 16'd1 : 16'd0;
  assign expired   = (dec_rem == 16'd0);
  assign can_retry = (rd.attempts <= {1'b0, retry_r});
  assign last_idx  = IW'(total - CW'(1));
  assign pend_now  = PEND_W'(total);
  assign pend_less = PEND_W'(total - CW'(1));

  // Datapath and table commands for the current sequencer step.
  always_comb begin
    cmd       = '0;
    cmd.op    = TOP_NOP;
    octl      = '0;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && func_t'(in_func) == FUNC_CANCEL) begin
          cmd.op = TOP_CLEAR;
        end
      end
      S_SEND: begin
        octl.push = 1'b1;
        res.unit  = unit_r;
        res.tag   = tag_r;
        if (total >= CW'(TABLE_DEPTH)) begin
          res.kind = EV_REJECTED;
          res.pend = pend_now;
        end else begin
          res.kind = EV_SENT;
          res.txn  = next_txn_r + 16'd1;
          res.att  = 5'd1;
          res.pend = PEND_W'(total + CW'(1));
          cmd.wdata.txn       = next_txn_r + 16'd1;
          cmd.wdata.unit      = unit_r;
          cmd.wdata.tag       = tag_r;
          cmd.wdata.attempts  = 5'd1;
          cmd.wdata.remaining = timeout_r;
          if (osts.push_ok) begin
            cmd.op = TOP_APPEND;
          end
        end
      end
      S_RESP: begin
        res.kind = EV_DROPPED;
        res.txn  = framing_r ? rtxn_r : 16'd0;
        res.pend = pend_now;
        if (total == '0 || !rok_r) begin
          octl.push = 1'b1;
        end else if (!framing_r || rd.txn == rtxn_r) begin
          octl.push = 1'b1;
          res.kind  = EV_COMPLETED;
          res.txn   = rd.txn;
          res.unit  = rd.unit;
          res.tag   = rd.tag;
          res.att   = rd.attempts;
          res.pend  = pend_less;
          if (osts.push_ok) begin
            cmd.op = TOP_REMOVE;
          end
        end else if (idx_r == last_idx) begin
          octl.push = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.wdata           = rd;
        cmd.wdata.remaining = dec_rem;
        if (expired && can_retry) begin
          octl.push           = 1'b1;
          cmd.wdata.attempts  = rd.attempts + 5'd1;
          cmd.wdata.remaining = timeout_r;
          res.kind = EV_RETRANSMIT;
          res.txn  = rd.txn;
          res.unit = rd.unit;
          res.tag  = rd.tag;
          res.att  = rd.attempts + 5'd1;
          res.pend = pend_now;
          if (osts.push_ok) begin
            cmd.op = TOP_WRITE;
          end
        end else begin
          cmd.op = TOP_WRITE;
        end
      end
      S_FAIL: begin
        if (fail_r[idx_r]) begin
          octl.push = 1'b1;
          res.kind  = EV_FAILED;
          res.txn   = rd.txn;
          res.unit  = rd.unit;
          res.tag   = rd.tag;
          res.att   = rd.attempts;
          res.pend  = pend_less;
          if (osts.push_ok) begin
            cmd.op = TOP_REMOVE;
          end
        end
      end
      S_FLUSH: begin
        octl.flush = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer: state and per-item registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      next_txn_r <= '0;
      idx_r      <= '0;
      fail_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unit_r <= in_unit_address;
            tag_r  <= in_request_tag;
            rtxn_r <= in_response_txn_id;
            rok_r  <= in_response_ok;
            idx_r  <= '0;
            fail_r <= '0;
            unique case (func_t'(in_func))
              FUNC_SEND: state_r <= S_SEND;
              FUNC_RESP: state_r <= S_RESP;
              FUNC_TICK: begin
                if (total == '0) begin
                  state_r <= S_FLUSH;
                end else begin
                  idx_r   <= last_idx;
                  state_r <= S_SCAN;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SEND: begin
          if (osts.push_ok) begin
            if (total < CW'(TABLE_DEPTH)) begin
              next_txn_r <= next_txn_r + 16'd1;
            end
            state_r <= S_FLUSH;
          end
        end
        S_RESP: begin
          if (octl.push) begin
            if (osts.push_ok) begin
              state_r <= S_FLUSH;
            end
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_SCAN: begin
          if (!octl.push || osts.push_ok) begin
            if (expired && !can_retry) begin
              fail_r[idx_r] <= 1'b1;
            end
            if (idx_r == '0) begin
              idx_r   <= last_idx;
              state_r <= S_FAIL;
            end else begin
              idx_r <= idx_r - IW'(1);
            end
          end
        end
        S_FAIL: begin
          if (!octl.push || osts.push_ok) begin
            fail_r[idx_r] <= 1'b0;
            if (idx_r == '0) begin
              state_r <= S_FLUSH;
            end else begin
              idx_r <= idx_r - IW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (osts.flush_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/mtt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level assertions for the transaction tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mtt_checker import mtt_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_event_kind,
  input wire logic [15:0] out_txn_id,
  input wire logic [4:0]  out_attempt_count,
  input wire logic [$clog2(TABLE_DEPTH+1)-1:0] out_pending_count
);

  // A working item keeps the input closed on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func != FUNC_CANCEL |=> !in_ready)
    else $error("input open right after a working item");

  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_count <= TABLE_DEPTH)
    else $error("pending count beyond table depth");

  a_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_SENT |-> out_attempt_count == 5'd1 &&
      out_txn_id != 16'd0 || out_attempt_count == 5'd1)
    else $error("new request without a single attempt");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind <= EV_FAILED)
    else $error("unknown result kind");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_txn_id))
    else $error("stalled result changed");

endmodule

bind modbus_transaction_tracker mtt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_mtt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_func           (in_func),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_event_kind    (out_event_kind),
  .out_txn_id        (out_txn_id),
  .out_attempt_count (out_attempt_count),
  .out_pending_count (out_pending_count)
);
`default_nettype wire

/* test/tracker_checker.sv */
// ----------------------------------------------------------------------------
// tracker_checker
// Watches both channels of the transaction tracker, keeps its own copy of the
// request table, and compares every result item against the expected events.
// ----------------------------------------------------------------------------
module tracker_checker import mtt_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_unit_address,
  input  wire logic [31:0] in_request_tag,
  input  wire logic [15:0] in_response_txn_id,
  input  wire logic        in_response_ok,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_event_kind,
  input  wire logic [15:0] out_txn_id,
  input  wire logic [7:0]  out_unit,
  input  wire logic [31:0] out_tag,
  input  wire logic [4:0]  out_attempt_count,
  input  wire logic [3:0]  out_pending_count,
  input  wire logic        out_last_of_run,
  output int               fail_count,
  output int               pending_events
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] txn;
    logic [7:0]  unit;
    logic [31:0] tag;
    logic [4:0]  att;
    logic [3:0]  pend;
    logic        last;
  } event_t;

  event_t      event_queue[$];
  logic        tcp_mode;
  logic [15:0] timeout_cfg;
  logic [3:0]  retry_cfg;
  entry_t      table_q[$];
  logic [15:0] txn_counter;

  assign pending_events = event_queue.size();

  function automatic event_t mk(logic [2:0] k, logic [15:0] t, logic [7:0] u,
                                logic [31:0] g, logic [4:0] a, int p);
    event_t e;
    e = '{k, t, u, g, a, p[3:0], 1'b0};
    return e;
  endfunction

  task automatic track_item(logic [1:0] f, logic [7:0] u, logic [31:0] g,
                            logic [15:0] rt, logic ok);
    event_t produced[$];
    entry_t ent;
    int     hit;
    int     pend;
    int     failed_idx[$];
    hit = -1;
    case (func_t'(f))
      FUNC_SEND: begin
        if (table_q.size() >= DEPTH) begin
          produced.push_back(mk(EV_REJECTED, 0, u, g, 0, table_q.size()));
        end else begin
          txn_counter = txn_counter + 16'd1;
          ent = '{txn_counter, u, g, 5'd1, timeout_cfg};
          table_q.push_back(ent);
          produced.push_back(mk(EV_SENT, txn_counter, u, g, 1, table_q.size()));
        end
      end
      FUNC_RESP: begin
        if (table_q.size() > 0 && ok) begin
          if (!tcp_mode) hit = 0;
          else begin
            for (int i = 0; i < table_q.size(); i++)
              if (hit < 0 && table_q[i].txn == rt) hit = i;
          end
        end
        if (hit >= 0) begin
          ent = table_q[hit];
          table_q.delete(hit);
          produced.push_back(mk(EV_COMPLETED, ent.txn, ent.unit, ent.tag,
                                ent.attempts, table_q.size()));
        end else begin
          produced.push_back(mk(EV_DROPPED, tcp_mode ? rt : 16'd0, 0, 0, 0,
                                table_q.size()));
        end
      end
      FUNC_TICK: begin
        pend = table_q.size();
        for (int i = table_q.size() - 1; i >= 0; i--) begin
          if (table_q[i].remaining > 0) table_q[i].remaining--;
          if (table_q[i].remaining == 0) begin
            if (table_q[i].attempts <= {1'b0, retry_cfg}) begin
              table_q[i].attempts++;
              table_q[i].remaining = timeout_cfg;
              produced.push_back(mk(EV_RETRANSMIT, table_q[i].txn, table_q[i].unit,
                                    table_q[i].tag, table_q[i].attempts, pend));
            end else failed_idx.push_back(i);
          end
        end
        // Indices are descending, so deleting in order keeps the rest valid.
        foreach (failed_idx[k]) begin
          ent = table_q[failed_idx[k]];
          table_q.delete(failed_idx[k]);
          produced.push_back(mk(EV_FAILED, ent.txn, ent.unit, ent.tag,
                                ent.attempts, table_q.size()));
        end
      end
      default: table_q.delete();
    endcase
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    foreach (produced[k]) event_queue.push_back(produced[k]);
  endtask

  always @(posedge clk) begin
    event_t got;
    if (!rst_n) begin
      tcp_mode    <= FRAMING_RESET;
      timeout_cfg <= TIMEOUT_RESET;
      retry_cfg   <= RETRY_RESET;
      txn_counter = '0;
      table_q.delete();
      event_queue.delete();
      fail_count  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAMING: tcp_mode <= cfg_wdata[0];
          CFG_TIMEOUT: timeout_cfg <= cfg_wdata;
          CFG_RETRY:   retry_cfg <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        track_item(in_func, in_unit_address, in_request_tag, in_response_txn_id,
                   in_response_ok);
      if (out_valid && out_ready) begin
        got = '{out_event_kind, out_txn_id, out_unit, out_tag, out_attempt_count,
                out_pending_count, out_last_of_run};
        if (event_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %h", got);
          fail_count <= fail_count + 1;
        end else begin
          if (got !== event_queue[0]) begin
            if (fail_count < 10)
              $display("mismatch: expected %h, got %h", event_queue[0], got);
            fail_count <= fail_count + 1;
          end
          void'(event_queue.pop_front());
        end
      end
    end
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives sends, responses, ticks and cancels into the transaction tracker under
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import mtt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FRAMING;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_func = FUNC_SEND;
  logic [7:0]  in_unit_address = '0;
  logic [31:0] in_request_tag = '0;
  logic [15:0] in_response_txn_id = '0;
  logic        in_response_ok = 1'b0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire [2:0]   out_event_kind;
  wire [15:0]  out_txn_id;
  wire [7:0]   out_unit;
  wire [31:0]  out_tag;
  wire [4:0]   out_attempt_count;
  wire [3:0]   out_pending_count;
  wire         out_last_of_run;
  int          fail_count;
  int          pending_events;
  int          quiet_cycles = 0;
  logic        long_hold = 1'b0;
  logic [15:0] last_txn = '0;

  localparam int WATCHDOG_LIMIT = 20000;

  always #2 clk = ~clk;

  modbus_transaction_tracker uut (.*);
  tracker_checker checker_i (.*);

  // Remember the newest id the block handed out so that TCP responses can
  // often hit a live entry.
  always @(posedge clk)
    if (out_valid && out_ready && out_event_kind == EV_SENT) last_txn <= out_txn_id;

  // The watchdog ends the run when nothing moves on either channel too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: a random stall before each item, sometimes none at all,
  // and a long hold-off while long_hold is raised.
  initial begin : receiver
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_item(logic [1:0] f, logic [7:0] u, logic [31:0] g,
                           logic [15:0] rt, logic ok, bit stall);
    int gap;
    gap = stall ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_func            <= f;
    in_unit_address    <= u;
    in_request_tag     <= g;
    in_response_txn_id <= rt;
    in_response_ok     <= ok;
    @(posedge clk iff in_ready);
  endtask

  // Registers change only with the block idle: drop valid, wait until every
  // expected result has arrived, then allow for a tick scan still running.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random item mix, weighted toward sends, responses and ticks.
  task automatic random_item(bit stall);
    int          pick;
    logic [15:0] rt;
    pick = $urandom_range(0, 99);
    rt   = ($urandom_range(0, 2) != 0) ? last_txn - 16'($urandom_range(0, 8))
                                       : 16'($urandom);
    if (pick < 40)
      send_item(FUNC_SEND, 8'($urandom), $urandom, 16'($urandom), 1'($urandom), stall);
    else if (pick < 65)
      send_item(FUNC_RESP, 8'($urandom), $urandom, rt,
                $urandom_range(0, 5) != 0, stall);
    else if (pick < 97)
      send_item(FUNC_TICK, 8'($urandom), $urandom, 16'($urandom), 1'($urandom), stall);
    else
      send_item(FUNC_CANCEL, 8'($urandom), $urandom, 16'($urandom), 1'($urandom),
                stall);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: timeout 0 expires on the first tick, retry 0 fails at once.
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_RETRY, 4'd0);
    send_item(FUNC_RESP, 8'h00, 32'h0, 16'h0, 1'b1, 0);      // nothing pending
    send_item(FUNC_TICK, 8'h00, 32'h0, 16'h0, 1'b0, 0);      // no result at all
    for (int i = 0; i < 9; i++)                              // ninth is rejected
      send_item(FUNC_SEND, (i[0] ? 8'hFF : 8'h00), (i[0] ? 32'hFFFF_FFFF : 32'h0),
                16'hFFFF, 1'b1, 0);
    send_item(FUNC_RESP, 8'h0, 32'h0, 16'h0, 1'b0, 0);       // bad frame
    send_item(FUNC_RESP, 8'h0, 32'h0, 16'h0, 1'b1, 0);       // RTU oldest
    send_item(FUNC_TICK, 8'h0, 32'h0, 16'h0, 1'b1, 0);       // all fail
    write_reg(CFG_FRAMING, 16'd1);
    write_reg(CFG_RETRY, 4'd15);
    write_reg(CFG_TIMEOUT, 16'd1);
    for (int i = 0; i < 3; i++) send_item(FUNC_SEND, 8'h5A, 32'hA5A5_0000, 0, 0, 0);
    send_item(FUNC_RESP, 8'h0, 32'h0, last_txn, 1'b1, 0);    // TCP match
    send_item(FUNC_RESP, 8'h0, 32'h0, 16'hFFFF, 1'b1, 0);    // TCP no match
    send_item(FUNC_TICK, 8'h0, 32'h0, 16'h0, 1'b1, 0);       // retransmits
    send_item(FUNC_CANCEL, 8'h0, 32'h0, 16'h0, 1'b1, 0);

    // Random phases over several settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_FRAMING, phase[0]);
      write_reg(CFG_TIMEOUT, (phase == 5) ? 16'hFFFF : 16'($urandom_range(0, 4)));
      write_reg(CFG_RETRY, (phase == 2) ? 16'd15 : 16'($urandom_range(0, 3)));
      if (phase == 3) long_hold = 1'b1;  // receiver stalls while we keep offering
      for (int n = 0; n < 75; n++) random_item(phase != 4);
    end

    in_valid <= 1'b0;
    while (pending_events != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
